// File: hdl/kmd_pkg.sv
// Shared types and constants for the key matrix debounce slot tracker.
// No dependencies; imported by every module of the block.
package kmd_pkg;

  localparam int KEY_COUNT_DEF   = 128;
  localparam int SLOT_COUNT_DEF  = 16;
  localparam int HISTORY_LEN_DEF = 3;

  localparam int KEY_IDX_W   = 7;
  localparam int SLOT_NUM_W  = 4;
  localparam int QUEUE_DEPTH = 2;

  // Classified request travelling from the front part to the back part.
  typedef struct packed {
    logic [KEY_IDX_W-1:0] key;
    logic                 raw;
    logic                 fend;
    logic                 in_range;
  } item_t;

  typedef struct packed {
    logic                  debounced;
    logic                  press_event;
    logic                  release_event;
    logic [SLOT_NUM_W-1:0] slot_number;
    logic                  dropped;
  } result_t;

endpackage

// File: hdl/kmd_front.sv
// Front part: accepts key samples, flags out-of-range keys, hands requests on.
// Depends on kmd_pkg.
module kmd_front
  import kmd_pkg::*;
#(
  parameter int KEY_COUNT = KEY_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  logic [KEY_IDX_W-1:0] key_index,
  input  logic                 raw_pressed,
  input  logic                 frame_end,
  output logic                 push,
  output item_t                push_item,
  input  logic                 queue_full
);

  logic  held;
  item_t item;
  logic  accept;

  assign sample_stall = held && queue_full;
  assign accept       = sample_valid && !sample_stall;
  assign push         = held && !queue_full;
  assign push_item    = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.key      <= key_index;
      item.raw      <= raw_pressed;
      item.fend     <= frame_end;
      item.in_range <= (9'(key_index) < 9'(KEY_COUNT));
    end
  end

endmodule

// File: hdl/kmd_queue.sv
// Short request queue between the front and back parts.
// Depends on kmd_pkg.
module kmd_queue
  import kmd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  head_valid,
  output item_t head_item,
  input  logic  pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// File: hdl/kmd_back.sv
// Back part: per-key state memory, debounce update, slot allocation, result register.
// Depends on kmd_pkg.
module kmd_back
  import kmd_pkg::*;
#(
  parameter int KEY_COUNT   = KEY_COUNT_DEF,
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    head_valid,
  input  item_t   head_item,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int KEY_AW  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PREV_W  = HISTORY_LEN - 1;
  localparam int ENTRY_W = PREV_W + 2 + SLOT_W;

  // Entry layout: {history, debounced, slot held, slot index}
  logic [ENTRY_W-1:0] mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] written;

  logic               s1_valid;
  item_t              s1_item;
  logic [KEY_AW-1:0]  s1_addr;
  logic [ENTRY_W-1:0] rd_word;
  logic               s1_adv;
  logic               s1_load;
  logic [KEY_AW-1:0]  head_addr;

  logic [SLOT_COUNT-1:0] busy;
  logic [SLOT_COUNT-1:0] freeing;
  logic [SLOT_COUNT-1:0] busy_next;
  logic [SLOT_COUNT-1:0] freeing_next;

  logic [PREV_W-1:0] hist;
  logic              old_deb;
  logic              held_slot;
  logic [SLOT_W-1:0] held_idx;
  logic              all_on;
  logic              any_on;
  logic              new_deb;
  logic [PREV_W-1:0] new_hist;
  logic              rel;
  logic              press_try;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              new_held;
  logic [SLOT_W-1:0] new_idx;
  logic              mem_we;
  logic [ENTRY_W-1:0] wdata;
  result_t           res_next;

  assign head_addr = KEY_AW'(head_item.key);
  assign s1_adv    = s1_valid && (!result_valid || !result_stall);
  assign s1_load   = head_valid && (!s1_valid || s1_adv);
  assign pop       = s1_load;
  assign mem_we    = s1_adv && s1_item.in_range;

  // Memory: one write, one registered read; bypass a write to the key being read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[s1_addr] <= wdata;
    end
    if (s1_load) begin
      if (mem_we && (s1_addr == head_addr)) begin
        rd_word <= wdata;
      end else if (written[head_addr]) begin
        rd_word <= mem[head_addr];
      end else begin
        rd_word <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (mem_we) begin
      written[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item <= head_item;
      s1_addr <= head_addr;
    end
  end

  always_comb begin
    hist      = rd_word[ENTRY_W-1 -: PREV_W];
    old_deb   = rd_word[SLOT_W+1];
    held_slot = rd_word[SLOT_W];
    held_idx  = rd_word[SLOT_W-1:0];
    all_on    = s1_item.raw && (hist == {PREV_W{1'b1}});
    any_on    = s1_item.raw || (hist != '0);
    new_deb   = (old_deb || all_on) && any_on;
    new_hist  = PREV_W'({hist, s1_item.raw});
    rel       = s1_item.in_range && held_slot && !new_deb;
    press_try = s1_item.in_range && !old_deb && all_on;

    // Lowest free slot
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end

    new_held = held_slot && !rel;
    new_idx  = held_idx;
    if (press_try && free_found) begin
      new_held = 1'b1;
      new_idx  = free_idx;
    end
    wdata = {new_hist, new_deb, new_held, new_idx};

    freeing_next = freeing;
    busy_next    = busy;
    if (rel) begin
      freeing_next = freeing | (SLOT_COUNT'(1) << held_idx);
    end
    if (press_try && free_found) begin
      busy_next = busy | (SLOT_COUNT'(1) << free_idx);
    end
    if (s1_item.fend) begin
      busy_next    = busy_next & ~freeing_next;
      freeing_next = '0;
    end

    res_next.debounced     = s1_item.in_range && new_deb;
    res_next.press_event   = press_try && free_found;
    res_next.release_event = rel;
    res_next.dropped       = press_try && !free_found;
    if (press_try && free_found) begin
      res_next.slot_number = SLOT_NUM_W'(free_idx);
    end else if (rel) begin
      res_next.slot_number = SLOT_NUM_W'(held_idx);
    end else begin
      res_next.slot_number = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      busy         <= '0;
      freeing      <= '0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= 1'b1;
        busy         <= busy_next;
        freeing      <= freeing_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result <= res_next;
    end
  end

endmodule

// File: hdl/key_matrix_debounce_slot_tracker.sv
// A sample passes the front register, queue, back stage and result register.
// Throughput: one sample per cycle unless stalled; the per-key state memory takes
// one read and one write each cycle, with a write bypass for a key repeated back to back.
// Reset (synchronous, active high) clears per-key valid bits, both slot masks
// and all handshake state at once; no clearing pass is needed.
// Top level: front part, request queue, back part. Depends on kmd_pkg.
module key_matrix_debounce_slot_tracker
  import kmd_pkg::*;
#(
  parameter int KEY_COUNT   = KEY_COUNT_DEF,
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  logic [KEY_IDX_W-1:0]  key_index,
  input  logic                  raw_pressed,
  input  logic                  frame_end,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic                  debounced,
  output logic                  press_event,
  output logic                  release_event,
  output logic [SLOT_NUM_W-1:0] slot_number,
  output logic                  dropped
);

  logic    push;
  item_t   push_item;
  logic    queue_full;
  logic    head_valid;
  item_t   head_item;
  logic    pop;
  result_t result;

  kmd_front #(
    .KEY_COUNT(KEY_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .key_index    (key_index),
    .raw_pressed  (raw_pressed),
    .frame_end    (frame_end),
    .push         (push),
    .push_item    (push_item),
    .queue_full   (queue_full)
  );

  kmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  kmd_back #(
    .KEY_COUNT   (KEY_COUNT),
    .SLOT_COUNT  (SLOT_COUNT),
    .HISTORY_LEN (HISTORY_LEN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign debounced     = result.debounced;
  assign press_event   = result.press_event;
  assign release_event = result.release_event;
  assign slot_number   = result.slot_number;
  assign dropped       = result.dropped;

`ifndef SYNTHESIS
  a_press_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid && press_event |-> debounced && !dropped && !release_event)
    else $error("press result inconsistent");

  a_release_off: assert property (@(posedge clk) disable iff (rst)
    result_valid && release_event |-> !debounced && !dropped)
    else $error("release result inconsistent");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !press_event && !release_event |-> slot_number == '0)
    else $error("slot number set without press or release");
`endif

endmodule
